// ===== src/assert_macros.svh =====
// assertion macros shared by the generator modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// check on clk_i, off while rst_ni is low
`define XSR_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("xsr assertion failed");

// check on an explicit clock and active-low reset
`define XSR_ASSERT_CLK(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("xsr assertion failed");

`else

`define XSR_ASSERT(label, prop)
`define XSR_ASSERT_CLK(label, clk, rstn, prop)

`endif

`endif

// ===== src/xsr_pkg.sv =====
// types and constants of the xoshiro256** generator with splitmix64 seeding
package xsr_pkg;

  localparam int unsigned WordW = 64;
  localparam int unsigned HalfW = WordW / 2;
  localparam int unsigned NumWords = 4;
  localparam int unsigned WordIdxW = $clog2(NumWords);
  localparam logic [WordIdxW-1:0] WordLast = WordIdxW'(NumWords - 1);

  localparam logic [WordW-1:0] GoldenGamma = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [WordW-1:0] MixMulA = 64'hBF58_476D_1CE4_E5B9;
  localparam logic [WordW-1:0] MixMulB = 64'h94D0_49BB_1331_11EB;

  localparam int unsigned MixShift0 = 30;
  localparam int unsigned MixShift1 = 27;
  localparam int unsigned MixShift2 = 31;
  localparam int unsigned XorShift = 17;
  localparam int unsigned RotState = 45;
  localparam int unsigned RotOut = 7;

  typedef enum logic [1:0] {
    ACT_NEXT = 2'd0,
    ACT_SEED = 2'd1,
    ACT_RESEED = 2'd2,
    ACT_NOP = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GAMMA,
    ST_MUL_LO,
    ST_MUL_X1,
    ST_MUL_X2,
    ST_MIX,
    ST_STORE
  } state_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_GAMMA,
    OP_MUL_LO,
    OP_MUL_X1,
    OP_MUL_X2,
    OP_MIX,
    OP_STORE
  } dp_op_e;

  typedef struct packed {
    action_e action;
    logic [WordW-1:0] seed_value;
  } in_item_t;

  typedef struct packed {
    logic [WordW-1:0] random_value;
    logic coin;
    logic [WordW-1:0] last_seed_value;
  } out_item_t;

  typedef struct packed {
    logic accept;
    action_e action;
    dp_op_e op;
    logic mul_b;
    logic [WordIdxW-1:0] word_idx;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic out_full;
  } sts_t;

endpackage

// ===== src/xsr_ctrl.sv =====
// controller: item acceptance and seed expansion sequencing
`include "assert_macros.svh"

module xsr_ctrl import xsr_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  action_e in_action_i,
  input  sts_t    sts_i,
  output logic    in_stall_o,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;
  logic phase_b_q, phase_b_d;
  logic [WordIdxW-1:0] idx_q, idx_d;
  logic boot_q, boot_d;
  logic idle_ready;
  logic accept;
  logic seed_go;

  assign idle_ready = (state_q == ST_IDLE) && !sts_i.out_full;
  assign in_stall_o = !idle_ready;
  assign accept = in_valid_i && idle_ready;
  assign seed_go = accept && (in_action_i == ACT_SEED || in_action_i == ACT_RESEED);

  // next state and sequence counters
  always_comb begin
    state_d = state_q;
    phase_b_d = phase_b_q;
    idx_d = idx_q;
    boot_d = boot_q;
    unique case (state_q)
      ST_IDLE: begin
        if (seed_go) begin
          state_d = ST_GAMMA;
        end
      end
      ST_GAMMA:  state_d = ST_MUL_LO;
      ST_MUL_LO: state_d = ST_MUL_X1;
      ST_MUL_X1: state_d = ST_MUL_X2;
      ST_MUL_X2: state_d = phase_b_q ? ST_STORE : ST_MIX;
      ST_MIX: begin
        state_d = ST_MUL_LO;
        phase_b_d = 1'b1;
      end
      ST_STORE: begin
        phase_b_d = 1'b0;
        idx_d = idx_q + 1'b1;
        if (idx_q == WordLast) begin
          state_d = ST_IDLE;
          boot_d = 1'b0;
        end else begin
          state_d = ST_GAMMA;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd_o.accept = accept;
    cmd_o.action = in_action_i;
    cmd_o.op = OP_NONE;
    cmd_o.mul_b = phase_b_q;
    cmd_o.word_idx = idx_q;
    cmd_o.out_load = 1'b0;
    unique case (state_q)
      ST_IDLE:   cmd_o.op = OP_NONE;
      ST_GAMMA:  cmd_o.op = OP_GAMMA;
      ST_MUL_LO: cmd_o.op = OP_MUL_LO;
      ST_MUL_X1: cmd_o.op = OP_MUL_X1;
      ST_MUL_X2: cmd_o.op = OP_MUL_X2;
      ST_MIX:    cmd_o.op = OP_MIX;
      ST_STORE: begin
        cmd_o.op = OP_STORE;
        cmd_o.out_load = (idx_q == WordLast) && !boot_q;
      end
      default:   cmd_o.op = OP_NONE;
    endcase
  end

  // boot expansion of seed zero starts right out of reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_GAMMA;
      phase_b_q <= 1'b0;
      idx_q <= '0;
      boot_q <= 1'b1;
    end else begin
      state_q <= state_d;
      phase_b_q <= phase_b_d;
      idx_q <= idx_d;
      boot_q <= boot_d;
    end
  end

  `XSR_ASSERT(a_seed_starts, seed_go |=> (state_q == ST_GAMMA))
  `XSR_ASSERT(a_idle_clean, (state_q == ST_IDLE) |-> (!phase_b_q && idx_q == '0))
  `XSR_ASSERT(a_boot_ends_idle, $fell(boot_q) |-> (state_q == ST_IDLE))

endmodule

// ===== src/xsr_dp.sv =====
// datapath: state words, seed accumulator, shared multiplier and result register
`include "assert_macros.svh"

module xsr_dp import xsr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cmd_t      cmd_i,
  input  in_item_t  in_item_i,
  input  logic      out_stall_i,
  output sts_t      sts_o,
  output logic      out_valid_o,
  output out_item_t out_item_o
);

  logic [WordW-1:0] words_q [NumWords];
  logic [WordW-1:0] acc_q;
  logic [WordW-1:0] seed_q;
  logic [WordW-1:0] z_q;
  logic [WordW-1:0] prod_q;
  logic [WordW-1:0] res_q;
  out_item_t out_q;
  logic out_valid_q;

  logic [WordW-1:0] mul5, rot7, draw_val, tmask;
  logic [WordW-1:0] w0_n, w1_n, w2_n, w3_n, w2_x, w3_x;
  logic [WordW-1:0] gamma_sum;
  logic [WordW-1:0] mul_const;
  logic [HalfW-1:0] mul_a, mul_b;
  logic [WordW-1:0] mul_p;
  logic load_now;

  // scrambled output and xoshiro256 state update
  always_comb begin
    mul5 = words_q[1] + (words_q[1] << 2);
    rot7 = (mul5 << RotOut) | (mul5 >> (WordW - RotOut));
    draw_val = rot7 + (rot7 << 3);
    tmask = words_q[1] << XorShift;
    w2_x = words_q[2] ^ words_q[0];
    w3_x = words_q[3] ^ words_q[1];
    w1_n = words_q[1] ^ w2_x;
    w0_n = words_q[0] ^ w3_x;
    w2_n = w2_x ^ tmask;
    w3_n = (w3_x << RotState) | (w3_x >> (WordW - RotState));
  end

  assign gamma_sum = acc_q + GoldenGamma;

  // one 32x32 multiplier, three passes per 64-bit product
  assign mul_const = cmd_i.mul_b ? MixMulB : MixMulA;
  always_comb begin
    mul_a = z_q[HalfW-1:0];
    mul_b = mul_const[HalfW-1:0];
    unique case (cmd_i.op)
      OP_MUL_X1: mul_b = mul_const[WordW-1:HalfW];
      OP_MUL_X2: mul_a = z_q[WordW-1:HalfW];
      default: ;
    endcase
  end
  assign mul_p = WordW'(mul_a) * WordW'(mul_b);

  assign load_now = cmd_i.out_load ||
                    (cmd_i.accept && (cmd_i.action == ACT_NEXT || cmd_i.action == ACT_NOP));

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_GAMMA:  z_q <= gamma_sum ^ (gamma_sum >> MixShift0);
      OP_MUL_LO: prod_q <= mul_p;
      OP_MUL_X1: prod_q <= prod_q + {mul_p[HalfW-1:0], HalfW'(0)};
      OP_MUL_X2: prod_q <= prod_q + {mul_p[HalfW-1:0], HalfW'(0)};
      OP_MIX:    z_q <= prod_q ^ (prod_q >> MixShift1);
      OP_STORE:  words_q[cmd_i.word_idx] <= prod_q ^ (prod_q >> MixShift2);
      default: ;
    endcase
    if (cmd_i.accept) begin
      unique case (cmd_i.action)
        ACT_NEXT: begin
          words_q[0] <= w0_n;
          words_q[1] <= w1_n;
          words_q[2] <= w2_n;
          words_q[3] <= w3_n;
          out_q.random_value <= draw_val;
          out_q.coin <= !draw_val[WordW-1];
          out_q.last_seed_value <= seed_q;
        end
        ACT_SEED: res_q <= '0;
        ACT_RESEED: begin
          words_q[0] <= w0_n;
          words_q[1] <= w1_n;
          words_q[2] <= w2_n;
          words_q[3] <= w3_n;
          res_q <= draw_val;
        end
        ACT_NOP: begin
          out_q.random_value <= '0;
          out_q.coin <= 1'b1;
          out_q.last_seed_value <= seed_q;
        end
        default: ;
      endcase
    end
    if (cmd_i.out_load) begin
      out_q.random_value <= res_q;
      out_q.coin <= !res_q[WordW-1];
      out_q.last_seed_value <= seed_q;
    end
  end

  // seed accumulator and recorded seed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      seed_q <= '0;
    end else if (cmd_i.accept && cmd_i.action == ACT_SEED) begin
      acc_q <= in_item_i.seed_value;
      seed_q <= in_item_i.seed_value;
    end else if (cmd_i.accept && cmd_i.action == ACT_RESEED) begin
      acc_q <= draw_val;
      seed_q <= draw_val;
    end else if (cmd_i.op == OP_GAMMA) begin
      acc_q <= gamma_sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_now) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign sts_o.out_full = out_valid_q && out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_item_o = out_q;

  `XSR_ASSERT(a_no_overwrite, load_now |-> !(out_valid_q && out_stall_i))
  `XSR_ASSERT(a_coin_match, out_valid_q |-> (out_q.coin == !out_q.random_value[WordW-1]))

endmodule

// ===== src/xoshiro256ss_with_splitmix64_seed_core.sv =====
// xoshiro256** generator with splitmix64 seeding, top level
// For a next-number item the scrambled output and the xor/shift/rotate
// state update are formed in the accepting cycle and land in the output register, so
// a new item is taken every cycle while the consumer keeps up. Seed and reseed items
// are accepted, then expanded into four chained splitmix64 words, each paced
// by the single shared 32x32 multiplier that forms each 64-bit product in
// three passes. After reset the block runs the same expansion of seed zero
// and stalls its input until done. Every item gives exactly one result item.
module xoshiro256ss_with_splitmix64_seed_core import xsr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  cmd_t cmd;
  sts_t sts;

  xsr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_action_i (in_item_i.action),
    .sts_i       (sts),
    .in_stall_o  (in_stall_o),
    .cmd_o       (cmd)
  );

  xsr_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_item_i   (in_item_i),
    .out_stall_i (out_stall_i),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o)
  );

endmodule

// ===== tb/sv/tb_top.sv =====
// testbench for the xoshiro256** generator core with splitmix64 seeding
`timescale 1ns / 100ps

module tb_top;
  import xsr_pkg::*;

  localparam int unsigned IdleLimit = 3000;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned RandItems = 1330;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned HoldAfter = 600;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  in_item_t  in_item = '0;
  logic      out_stall = 1'b0;
  logic      in_stall_o;
  logic      out_valid_o;
  out_item_t out_item_o;

  xoshiro256ss_with_splitmix64_seed_core u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall),
    .out_item_o (out_item_o)
  );

  always #5 clk_i = ~clk_i;

  // generator state mirror
  logic [WordW-1:0] gen_word [NumWords];
  logic [WordW-1:0] seed_word;

  in_item_t  stim_items [$];
  out_item_t expected_draws [$];
  out_item_t mon_want;

  int items_sent = 0;
  int results_seen = 0;
  int coins_set = 0;
  int mismatches = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  int gap_left = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int stall_mode = 0;
  int stall_phase = 0;
  int stall_tick = 0;
  int n_act [4] = '{0, 0, 0, 0};

  function automatic logic [WordW-1:0] rotl64(logic [WordW-1:0] v, int unsigned k);
    return (v << k) | (v >> (WordW - k));
  endfunction

  function automatic void seed_generator(logic [WordW-1:0] s);
    logic [WordW-1:0] acc;
    logic [WordW-1:0] z;
    seed_word = s;
    acc = s;
    for (int i = 0; i < NumWords; i++) begin
      acc = acc + GoldenGamma;
      z = acc;
      z = (z ^ (z >> MixShift0)) * MixMulA;
      z = (z ^ (z >> MixShift1)) * MixMulB;
      gen_word[i] = z ^ (z >> MixShift2);
    end
  endfunction

  function automatic logic [WordW-1:0] draw_word();
    logic [WordW-1:0] res;
    logic [WordW-1:0] t;
    res = rotl64(gen_word[1] * 64'd5, RotOut) * 64'd9;
    t = gen_word[1] << XorShift;
    gen_word[2] = gen_word[2] ^ gen_word[0];
    gen_word[3] = gen_word[3] ^ gen_word[1];
    gen_word[1] = gen_word[1] ^ gen_word[2];
    gen_word[0] = gen_word[0] ^ gen_word[3];
    gen_word[2] = gen_word[2] ^ t;
    gen_word[3] = rotl64(gen_word[3], RotState);
    return res;
  endfunction

  function automatic out_item_t step_generator(in_item_t it);
    out_item_t r;
    logic [WordW-1:0] v;
    v = '0;
    case (it.action)
      ACT_NEXT: v = draw_word();
      ACT_SEED: seed_generator(it.seed_value);
      ACT_RESEED: begin
        v = draw_word();
        seed_generator(v);
      end
      default: ;
    endcase
    r.random_value = v;
    r.coin = ~v[WordW-1];
    r.last_seed_value = seed_word;
    return r;
  endfunction

  function automatic logic [WordW-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  task automatic add_item(action_e act, logic [WordW-1:0] val);
    in_item_t it;
    it.action = act;
    it.seed_value = val;
    stim_items.push_back(it);
    n_act[act]++;
  endtask

  // sender: bursts of items with random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_item <= '0;
    end else begin
      if (in_valid && !in_stall_o) begin
        expected_draws.push_back(step_generator(in_item));
        items_sent++;
      end
      if (!in_valid || !in_stall_o) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (stim_items.size() != 0) begin
          in_valid <= 1'b1;
          in_item <= stim_items.pop_front();
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 3) == 0) gap_left = 0;
            else if ($urandom_range(0, 4) == 0) gap_left = $urandom_range(13, 50);
            else gap_left = $urandom_range(1, 12);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall pattern, with one long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      stall_tick++;
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!hold_done && items_sent >= HoldAfter) begin
        hold_done = 1'b1;
        hold_left = HoldCycles;
        out_stall <= 1'b1;
      end else begin
        if (stall_phase == 0) begin
          stall_mode = $urandom_range(0, 3);
          stall_phase = $urandom_range(10, 80);
        end else begin
          stall_phase--;
        end
        case (stall_mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 99) < 25);
          2: out_stall <= ($urandom_range(0, 99) < 70);
          default: out_stall <= (stall_tick % 3 != 0);
        endcase
      end
    end
  end

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall) begin
      results_seen++;
      if (out_item_o.coin) coins_set++;
      if (expected_draws.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result item %h", $time, out_item_o);
      end else begin
        mon_want = expected_draws.pop_front();
        if (out_item_o.random_value !== mon_want.random_value) begin
          mismatches++;
          $display("%0t: random_value expected %h actual %h", $time,
                   mon_want.random_value, out_item_o.random_value);
        end
        if (out_item_o.coin !== mon_want.coin) begin
          mismatches++;
          $display("%0t: coin expected %b actual %b", $time, mon_want.coin, out_item_o.coin);
        end
        if (out_item_o.last_seed_value !== mon_want.last_seed_value) begin
          mismatches++;
          $display("%0t: last_seed_value expected %h actual %h", $time,
                   mon_want.last_seed_value, out_item_o.last_seed_value);
        end
      end
    end
  end

  // watchdog on cycles with no item moving
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("%0t: no item moved for %0d cycles", $time, idle_cycles);
        $display("tb_top NOT OK");
        $finish;
      end
    end
  end

  initial begin
    int r;
    int n_total;
    logic [WordW-1:0] v;
    seed_generator('0);

    // directed items
    add_item(ACT_NEXT, rand_word());
    add_item(ACT_NEXT, '1);
    add_item(ACT_NEXT, '0);
    add_item(ACT_SEED, '0);
    add_item(ACT_NEXT, rand_word());
    add_item(ACT_SEED, '1);
    add_item(ACT_NEXT, '0);
    add_item(ACT_NEXT, '1);
    add_item(ACT_SEED, 64'h8000_0000_0000_0000);
    add_item(ACT_NEXT, '0);
    add_item(ACT_SEED, 64'h7FFF_FFFF_FFFF_FFFF);
    add_item(ACT_NEXT, '0);
    add_item(ACT_SEED, 64'd1);
    add_item(ACT_RESEED, rand_word());
    add_item(ACT_NEXT, '0);
    add_item(ACT_RESEED, '1);
    add_item(ACT_RESEED, '0);
    add_item(ACT_NOP, '1);
    add_item(ACT_NOP, '0);
    add_item(ACT_NEXT, rand_word());
    // first mix step wraps the accumulator to zero
    add_item(ACT_SEED, 64'h0 - GoldenGamma);
    add_item(ACT_NEXT, '0);
    add_item(ACT_NOP, rand_word());

    // random items
    for (int i = 0; i < RandItems; i++) begin
      r = $urandom_range(0, 99);
      case ($urandom_range(0, 5))
        0: v = '0;
        1: v = '1;
        2: v = 64'($urandom_range(0, 255));
        3: v = 64'h1 << $urandom_range(0, 63);
        default: v = rand_word();
      endcase
      if (r < 55) add_item(ACT_NEXT, rand_word());
      else if (r < 75) add_item(ACT_SEED, v);
      else if (r < 90) add_item(ACT_RESEED, rand_word());
      else add_item(ACT_NOP, v);
    end
    n_total = stim_items.size();

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (items_sent < n_total || expected_draws.size() != 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("covered %0d next, %0d seed, %0d reseed, %0d unused-code items",
             n_act[ACT_NEXT], n_act[ACT_SEED], n_act[ACT_RESEED], n_act[ACT_NOP]);
    $display("checked %0d results, %0d with coin set, one long output hold-off",
             results_seen, coins_set);
    if (mismatches == 0 && expected_draws.size() == 0 && results_seen == items_sent) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
